// ----- rtl/lmt_pkg.sv -----
// ----------------------------------------------------------------------------
// lmt_pkg
// Shared types and timing constants for the lcd line and mode timing block.
// ----------------------------------------------------------------------------
package lmt_pkg;

  localparam int unsigned DotW = 17;

  localparam logic [DotW-1:0] DotsLine  = 17'd456;
  localparam logic [DotW-1:0] OamEnd    = 17'd80;
  localparam logic [DotW-1:0] DrawEnd   = 17'd252;
  localparam logic [DotW-1:0] DotsFrame = 17'd70224;
  localparam logic [8:0]      DotSat    = 9'd455;
  localparam logic [7:0]      VblFirst  = 8'd144;
  localparam logic [7:0]      LinesFrame = 8'd154;
  localparam logic [7:0]      LineZero  = 8'd0;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_LCD_ENABLE     = 3'd0,
    CFG_COMPARE_LINE   = 3'd1,
    CFG_IRQ_EN_HBLANK  = 3'd2,
    CFG_IRQ_EN_VBLANK  = 3'd3,
    CFG_IRQ_EN_OAM     = 3'd4,
    CFG_IRQ_EN_COMPARE = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic       lcd_enable;
    logic [7:0] compare_line;
    logic       irq_en_hblank;
    logic       irq_en_vblank;
    logic       irq_en_oam;
    logic       irq_en_compare;
  } cfg_t;

  typedef struct packed {
    logic [DotW-1:0] dot;
    logic [7:0]      line;
    mode_e           mode;
    logic            match;
    logic [31:0]     frame;
  } state_t;

  typedef struct packed {
    logic       vbl;
    logic       stat;
    logic       go;
    logic [7:0] row;
  } pulse_t;

  // packed so that line_now sits in the lowest bits
  typedef struct packed {
    logic [31:0] frames_done;
    logic [7:0]  render_row;
    logic        render_go;
    logic        stat_irq;
    logic        vblank_irq;
    logic        line_match;
    logic [1:0]  mode_now;
    logic [7:0]  line_now;
  } result_t;

endpackage

// ----- rtl/lcd_line_mode_timing.sv -----
// ----------------------------------------------------------------------------
// lcd_line_mode_timing
// Dot, line and mode timing of an lcd controller with interrupt and render
// pulses, one result beat per dot-count beat.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                                  | beat
//  s        | in  | s_tvalid_i s_tready_o s_tdata_i[15:0]    | dots_elapsed
//  m        | out | m_tvalid_o m_tready_i m_tdata_o[55:0]    | timing result
//  cfg      | in  | cfg_valid_i cfg_ready_o cfg_index_i      | register write
//           |     | cfg_data_i[7:0]                          |
//
//  one cycle per beat, back to back, while the display runs and the result
//  buffer has room; the first beat after the display is switched on is
//  worked off 456 dots at a time: the step unit consumes one line per
//  cycle while the buffer has room, and s_tready_o stays low meanwhile
//  reset clears configuration and timing state, mode resets to oam search
//  a two-entry result buffer keeps input beats flowing while a result waits
// ----------------------------------------------------------------------------
module lcd_line_mode_timing (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,   // [8:0] dots_elapsed
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // [7:0] line_now, [9:8] mode_now, [10] line_match, [11] vblank_irq,
  // [12] stat_irq, [13] render_go, [21:14] render_row, [53:22] frames_done
  output logic [55:0] m_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_CATCH = 2'b10
  } st_e;

  st_e                      st_q, st_d;
  lmt_pkg::cfg_t            cfg_q;
  lmt_pkg::state_t          state_q, state_next;
  lmt_pkg::pulse_t          pulse, acc_q, acc_d, acc_in;
  logic                     more;
  logic                     fifo_ready;
  logic                     work_en;
  logic                     push;
  logic [8:0]               dots_sat;
  logic [lmt_pkg::DotW-1:0] pos;
  lmt_pkg::result_t         res, res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (lmt_pkg::cfg_idx_e'(cfg_index_i))
        lmt_pkg::CFG_LCD_ENABLE:     cfg_q.lcd_enable     <= cfg_data_i[0];
        lmt_pkg::CFG_COMPARE_LINE:   cfg_q.compare_line   <= cfg_data_i;
        lmt_pkg::CFG_IRQ_EN_HBLANK:  cfg_q.irq_en_hblank  <= cfg_data_i[0];
        lmt_pkg::CFG_IRQ_EN_VBLANK:  cfg_q.irq_en_vblank  <= cfg_data_i[0];
        lmt_pkg::CFG_IRQ_EN_OAM:     cfg_q.irq_en_oam     <= cfg_data_i[0];
        lmt_pkg::CFG_IRQ_EN_COMPARE: cfg_q.irq_en_compare <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign s_tready_o = (st_q == ST_IDLE) && fifo_ready;
  assign work_en    = fifo_ready && ((st_q == ST_CATCH) || s_tvalid_i);

  assign dots_sat = (s_tdata_i[8:0] > lmt_pkg::DotSat) ? lmt_pkg::DotSat : s_tdata_i[8:0];

  always_comb begin
    if (st_q == ST_CATCH) begin
      pos    = state_q.dot;
      acc_in = acc_q;
    end else begin
      pos    = state_q.dot + {{(lmt_pkg::DotW-9){1'b0}}, dots_sat};
      acc_in = '0;
    end
  end

  lmt_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .pos_i   (pos),
    .state_o (state_next),
    .pulse_o (pulse),
    .more_o  (more)
  );

  // pulses raised on every line of a catch-up are merged into one result
  always_comb begin
    acc_d      = acc_in;
    acc_d.vbl  = acc_in.vbl | pulse.vbl;
    acc_d.stat = acc_in.stat | pulse.stat;
    acc_d.go   = pulse.go;
    acc_d.row  = pulse.row;
    st_d       = st_q;
    push       = 1'b0;
    if (work_en) begin
      st_d = more ? ST_CATCH : ST_IDLE;
      push = !more;
    end
  end

  always_comb begin
    res.line_now    = state_next.line;
    res.mode_now    = state_next.mode;
    res.line_match  = state_next.match;
    res.vblank_irq  = acc_d.vbl;
    res.stat_irq    = acc_d.stat;
    res.render_go   = acc_d.go;
    res.render_row  = acc_d.row;
    res.frames_done = state_next.frame;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= ST_IDLE;
      acc_q         <= '0;
      state_q.dot   <= '0;
      state_q.line  <= lmt_pkg::LineZero;
      state_q.mode  <= lmt_pkg::MODE_OAM;
      state_q.match <= 1'b0;
      state_q.frame <= 32'd0;
    end else begin
      st_q <= st_d;
      if (work_en) begin
        state_q <= state_next;
        acc_q   <= acc_d;
      end
    end
  end

  lmt_out_fifo u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (res),
    .ready_o     (fifo_ready),
    .valid_o     (m_tvalid_o),
    .pop_ready_i (m_tready_i),
    .data_o      (res_out)
  );

  assign m_tdata_o = {2'b00, res_out};

endmodule

// ----- rtl/lmt_step.sv -----
// ----------------------------------------------------------------------------
// lmt_step
// One timing step: takes at most one line off the dot position (a frame
// with the display off) and derives line, mode, coincidence and pulses.
// ----------------------------------------------------------------------------
module lmt_step (
  input  lmt_pkg::cfg_t              cfg_i,
  input  lmt_pkg::state_t            state_i,
  input  logic [lmt_pkg::DotW-1:0]   pos_i,
  output lmt_pkg::state_t            state_o,
  output lmt_pkg::pulse_t            pulse_o,
  output logic                       more_o
);

  always_comb begin
    lmt_pkg::state_t         nxt;
    lmt_pkg::pulse_t         pls;
    logic [7:0]              line_inc;
    logic [lmt_pkg::DotW-1:0] pos_l;
    lmt_pkg::mode_e          m;
    logic                    more;

    nxt      = state_i;
    pls      = '0;
    line_inc = state_i.line + 8'd1;
    pos_l    = pos_i;
    m        = lmt_pkg::MODE_HBLANK;
    more     = 1'b0;

    if (!cfg_i.lcd_enable) begin
      // display off: free-running frame timer only
      if (pos_i >= lmt_pkg::DotsFrame) begin
        nxt.dot   = pos_i - lmt_pkg::DotsFrame;
        nxt.frame = state_i.frame + 32'd1;
      end else begin
        nxt.dot = pos_i;
      end
      nxt.line = lmt_pkg::LineZero;
      nxt.mode = lmt_pkg::MODE_HBLANK;
    end else begin
      if (pos_i >= lmt_pkg::DotsLine) begin
        pos_l = pos_i - lmt_pkg::DotsLine;
        if (line_inc == lmt_pkg::VblFirst) begin
          nxt.line  = line_inc;
          nxt.mode  = lmt_pkg::MODE_VBLANK;
          pls.vbl   = 1'b1;
          nxt.frame = state_i.frame + 32'd1;
          if (cfg_i.irq_en_vblank ||
              (cfg_i.irq_en_compare && (line_inc == cfg_i.compare_line))) begin
            pls.stat = 1'b1;
          end
        end else if (line_inc >= lmt_pkg::LinesFrame) begin
          nxt.line = lmt_pkg::LineZero;
          nxt.mode = lmt_pkg::MODE_OAM;
          if (cfg_i.irq_en_oam ||
              (cfg_i.irq_en_compare && (cfg_i.compare_line == lmt_pkg::LineZero))) begin
            pls.stat = 1'b1;
          end
        end else begin
          nxt.line = line_inc;
        end
        nxt.match = (nxt.line == cfg_i.compare_line);
        if (nxt.match && cfg_i.irq_en_compare) begin
          pls.stat = 1'b1;
        end
      end
      nxt.dot = pos_l;
      more    = (pos_l >= lmt_pkg::DotsLine);

      // mode within a visible line, only once all whole lines are consumed
      if (!more && (nxt.line < lmt_pkg::VblFirst)) begin
        if (pos_l < lmt_pkg::OamEnd) begin
          m = lmt_pkg::MODE_OAM;
        end else if (pos_l < lmt_pkg::DrawEnd) begin
          m = lmt_pkg::MODE_DRAW;
        end else begin
          m = lmt_pkg::MODE_HBLANK;
        end
        if (m != nxt.mode) begin
          if (m == lmt_pkg::MODE_HBLANK) begin
            pls.go  = 1'b1;
            pls.row = nxt.line;
          end
          nxt.mode = m;
          if (((m == lmt_pkg::MODE_HBLANK) && cfg_i.irq_en_hblank) ||
              ((m == lmt_pkg::MODE_OAM) && cfg_i.irq_en_oam) ||
              (cfg_i.irq_en_compare && (nxt.line == cfg_i.compare_line))) begin
            pls.stat = 1'b1;
          end
        end
      end
    end

    state_o = nxt;
    pulse_o = pls;
    more_o  = more;
  end

endmodule

// ----- rtl/lmt_out_fifo.sv -----
// ----------------------------------------------------------------------------
// lmt_out_fifo
// Two-entry result buffer between the step logic and the output channel.
// ----------------------------------------------------------------------------
module lmt_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lmt_pkg::result_t  data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output lmt_pkg::result_t  data_o
);

  lmt_pkg::result_t ent_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign valid_o = (cnt_q != 2'd0);
  assign ready_o = (cnt_q != 2'd2);
  assign data_o  = ent_q[rd_q];
  assign pop     = valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    unique case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/lmt_checker.sv -----
// ----------------------------------------------------------------------------
// lmt_checker
// Port-level checks on the result channel of the lcd timing block.
// ----------------------------------------------------------------------------
module lmt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [55:0] m_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result beat changed while stalled");

  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tdata_o[7:0] <= 8'd153)
    else $error("line beyond last line of frame");

  a_vblank_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tdata_o[9:8] == lmt_pkg::MODE_VBLANK)
      |-> m_tdata_o[7:0] >= lmt_pkg::VblFirst)
    else $error("vblank mode on a visible line");

  a_row_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tdata_o[13] |-> m_tdata_o[21:14] == 8'd0)
    else $error("render row set without render pulse");

  a_render: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[13] |-> (m_tdata_o[9:8] == lmt_pkg::MODE_HBLANK) &&
      (m_tdata_o[21:14] == m_tdata_o[7:0]) && (m_tdata_o[7:0] < lmt_pkg::VblFirst))
    else $error("render pulse outside hblank of a visible line");

endmodule

bind lcd_line_mode_timing lmt_checker u_lmt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);

// ----- bench/tb_lcd_line_mode_timing.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lcd_line_mode_timing
// Self-checking bench for the lcd line and mode timing block. A clocked
// driver sends dot-count beats from a pending queue and predicts each
// result from its own model of the dot, line, mode and frame state. A
// clocked monitor compares every result beat field by field against the
// oldest prediction. Both sides stall at random. Registers change only
// while the block is idle, between phases of directed and random beats.
// ----------------------------------------------------------------------------
module tb_lcd_line_mode_timing;
  import lmt_pkg::*;

  localparam int          WatchdogLimit = 1000;
  localparam int          MaxReports    = 10;
  localparam logic [2:0]  CfgSpareLo    = 3'd6;
  localparam logic [2:0]  CfgSpareHi    = 3'd7;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        s_tvalid_i  = 1'b0;
  logic        s_tready_o;
  logic [15:0] s_tdata_i   = '0;
  logic        m_tvalid_o;
  logic        m_tready_i  = 1'b0;
  logic [55:0] m_tdata_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i  = '0;

  lcd_line_mode_timing dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),   // [8:0] dots_elapsed
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    // [7:0] line_now, [9:8] mode_now, [10] line_match, [11] vblank_irq,
    // [12] stat_irq, [13] render_go, [21:14] render_row, [53:22] frames_done
    .m_tdata_o   (m_tdata_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // register copies
  logic       lcd_on   = 1'b0;
  logic [7:0] cmp_line = '0;
  logic       en_hbl   = 1'b0;
  logic       en_vbl   = 1'b0;
  logic       en_oam   = 1'b0;
  logic       en_cmp   = 1'b0;

  // timing state copies
  logic [DotW-1:0] dot_q   = '0;
  logic [7:0]      line_q  = '0;
  mode_e           mode_q  = MODE_OAM;
  logic            match_q = 1'b0;
  logic [31:0]     frame_q = '0;

  logic [8:0] dots_pending_q[$];
  result_t    timing_exp_q[$];

  int fail_count  = 0;
  int idle_cycles = 0;
  int tx_wait = 0;
  int tx_run  = 0;
  int rx_wait = 0;
  int rx_run  = 0;

  function automatic logic stat_cause();
    return (mode_q == MODE_HBLANK && en_hbl) || (mode_q == MODE_VBLANK && en_vbl) ||
           (mode_q == MODE_OAM && en_oam) || (en_cmp && line_q == cmp_line);
  endfunction

  function automatic result_t advance_timing(logic [8:0] dots_in);
    result_t    r;
    logic [8:0] d;
    mode_e      m;
    logic       vbl;
    logic       stat;
    logic       go;
    logic [7:0] row;
    d    = (dots_in > DotSat) ? DotSat : dots_in;
    vbl  = 1'b0;
    stat = 1'b0;
    go   = 1'b0;
    row  = LineZero;
    dot_q = dot_q + {{(DotW-9){1'b0}}, d};
    if (!lcd_on) begin
      if (dot_q >= DotsFrame) begin
        dot_q   = dot_q - DotsFrame;
        frame_q = frame_q + 32'd1;
      end
      line_q = LineZero;
      mode_q = MODE_HBLANK;
    end else begin
      // a long off period is worked off one line at a time
      while (dot_q >= DotsLine) begin
        dot_q  = dot_q - DotsLine;
        line_q = line_q + 8'd1;
        if (line_q == VblFirst) begin
          mode_q  = MODE_VBLANK;
          vbl     = 1'b1;
          stat    = stat | stat_cause();
          frame_q = frame_q + 32'd1;
        end else if (line_q >= LinesFrame) begin
          line_q = LineZero;
          mode_q = MODE_OAM;
          stat   = stat | stat_cause();
        end
        match_q = (line_q == cmp_line);
        if (match_q && en_cmp) stat = 1'b1;
      end
      if (line_q < VblFirst) begin
        if (dot_q < OamEnd) m = MODE_OAM;
        else if (dot_q < DrawEnd) m = MODE_DRAW;
        else m = MODE_HBLANK;
        if (m != mode_q) begin
          if (m == MODE_HBLANK) begin
            go  = 1'b1;
            row = line_q;
          end
          mode_q = m;
          stat   = stat | stat_cause();
        end
      end
    end
    r.line_now    = line_q;
    r.mode_now    = mode_q;
    r.line_match  = match_q;
    r.vblank_irq  = vbl;
    r.stat_irq    = stat;
    r.render_go   = go;
    r.render_row  = row;
    r.frames_done = frame_q;
    return r;
  endfunction

  // idle cycles before the next beat, with runs of back-to-back beats
  task automatic draw_wait(inout int run_left, output int cycles);
    if (run_left > 0) begin
      run_left--;
      cycles = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      run_left = $urandom_range(8, 30);
      cycles   = 0;
    end else begin
      cycles = $urandom_range(0, 13);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MaxReports)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic take;
    logic hold;
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
      s_tdata_i  <= '0;
    end else begin
      take = s_tvalid_i && s_tready_o;
      hold = s_tvalid_i && !take;
      if (take) begin
        timing_exp_q.push_back(advance_timing(s_tdata_i[8:0]));
        draw_wait(tx_run, tx_wait);
      end
      if (!hold) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (dots_pending_q.size() != 0) begin
          hold = 1'b1;
          s_tdata_i <= {7'd0, dots_pending_q.pop_front()};
        end
      end
      s_tvalid_i <= hold;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else begin
      if (m_tvalid_o && m_tready_i) begin
        if (timing_exp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("%0t: result beat with nothing expected, got %h", $realtime, m_tdata_o);
        end else begin
          want = timing_exp_q.pop_front();
          got  = m_tdata_o[53:0];
          check_field("line_now",    32'(want.line_now),    32'(got.line_now));
          check_field("mode_now",    32'(want.mode_now),    32'(got.mode_now));
          check_field("line_match",  32'(want.line_match),  32'(got.line_match));
          check_field("vblank_irq",  32'(want.vblank_irq),  32'(got.vblank_irq));
          check_field("stat_irq",    32'(want.stat_irq),    32'(got.stat_irq));
          check_field("render_go",   32'(want.render_go),   32'(got.render_go));
          check_field("render_row",  32'(want.render_row),  32'(got.render_row));
          check_field("frames_done", want.frames_done,      got.frames_done);
          check_field("tdata pad",   32'd0,                 32'(m_tdata_o[55:54]));
        end
        draw_wait(rx_run, rx_wait);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LCD_ENABLE:     lcd_on   = data[0];
      CFG_COMPARE_LINE:   cmp_line = data;
      CFG_IRQ_EN_HBLANK:  en_hbl   = data[0];
      CFG_IRQ_EN_VBLANK:  en_vbl   = data[0];
      CFG_IRQ_EN_OAM:     en_oam   = data[0];
      CFG_IRQ_EN_COMPARE: en_cmp   = data[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // one-bit registers get random upper bits, which the block must ignore
  task automatic set_config(input logic lcd, input logic [7:0] cmp, input logic hbl,
                            input logic vbl, input logic oam, input logic cmpen);
    logic [7:0] noise;
    noise = 8'($urandom);
    write_reg(CFG_IRQ_EN_HBLANK, {noise[7:1], hbl});
    noise = 8'($urandom);
    write_reg(CFG_IRQ_EN_VBLANK, {noise[7:1], vbl});
    noise = 8'($urandom);
    write_reg(CFG_IRQ_EN_OAM, {noise[7:1], oam});
    noise = 8'($urandom);
    write_reg(CFG_IRQ_EN_COMPARE, {noise[7:1], cmpen});
    write_reg(CFG_COMPARE_LINE, cmp);
    if ($urandom_range(0, 2) == 0) begin
      noise = 8'($urandom);
      write_reg($urandom_range(0, 1) ? CfgSpareHi : CfgSpareLo, noise);
    end
    noise = 8'($urandom);
    write_reg(CFG_LCD_ENABLE, {noise[7:1], lcd});
  endtask

  task automatic wait_idle();
    while (dots_pending_q.size() != 0 || s_tvalid_i || timing_exp_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // mostly steps of up to a line to get through frames, some small ones to
  // land on mode edges, some above the saturation point
  task automatic push_random(input int count, input logic big_only);
    int         pick;
    logic [8:0] d;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 19);
      if (big_only) d = 9'($urandom_range(400, 511));
      else if (pick < 11) d = 9'($urandom_range(0, 455));
      else if (pick < 16) d = 9'($urandom_range(0, 40));
      else if (pick < 18) d = 9'($urandom_range(456, 511));
      else d = $urandom_range(0, 1) ? DotSat : 9'd0;
      dots_pending_q.push_back(d);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // display off with reset settings, saturation included
    dots_pending_q = '{9'd0, 9'd455, 9'd511, 9'd256, 9'd1};
    wait_idle();

    // switch on over a small leftover dot position, then walk the mode edges
    set_config(1'b1, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
    dots_pending_q = '{9'd0, 9'd201, 9'd79, 9'd1, 9'd171, 9'd1, 9'd203, 9'd1,
                       9'd455, 9'd456, 9'd511, 9'd0, 9'd256, 9'd128, 9'd64,
                       9'd32, 9'd16, 9'd8, 9'd4, 9'd2};
    wait_idle();

    // long off period so the frame count can advance while dark
    set_config(1'b0, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1);
    push_random(170, 1'b1);
    wait_idle();

    // switching on here can consume up to a frame of dots in one beat
    set_config(1'b1, 8'd255, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    push_random(80, 1'b0);
    wait_idle();

    set_config(1'b1, 8'd153, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'b1);
    push_random(80, 1'b0);
    wait_idle();

    set_config(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
    push_random(40, 1'b0);
    wait_idle();

    set_config(1'b1, 8'd144, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    push_random(80, 1'b0);
    wait_idle();

    set_config(1'b1, 8'($urandom_range(0, 153)), 1'b0, 1'b0, 1'b0, 1'b0);
    push_random(60, 1'b0);
    wait_idle();

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
